// ----- src/assert_macros.svh -----
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define CHK_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("check failed");
// Next-cycle implication checked outside reset.
`define CHK_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("check failed");
`endif

// ----- src/chkv_pkg.sv -----
// Shared types and codes for the chained hash key-value table.
`default_nettype none
package chkv_pkg;
    localparam logic [1:0] KIND_PUT = 2'd0;
    localparam logic [1:0] KIND_GET = 2'd1;
    localparam logic [1:0] KIND_REMOVE = 2'd2;
    localparam logic [31:0] HASH_MASK = 32'h7fff_ffff;

    typedef struct packed {
        logic [1:0] kind;
        logic signed [31:0] key;
        logic [31:0] value;
    } in_item_t;

    typedef struct packed {
        logic found;
        logic [31:0] value_out;
        logic released_valid;
        logic [31:0] released_value;
        logic status;
        logic [8:0] entry_count;
    } out_item_t;

    typedef enum logic [3:0] {
        ST_INIT, ST_IDLE, ST_HEAD, ST_WALK, ST_CMP, ST_PUTNEW, ST_PUTFREE,
        ST_REMOVE, ST_DONE
    } state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic init_step;
        logic load_item;
        logic read_head;
        logic read_entry;
        logic advance;
        logic do_replace;
        logic do_get;
        logic do_insert;
        logic do_full;
        logic do_unlink;
        logic do_remove;
        logic do_finish;
        logic read_free;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic init_done;
        logic cur_nil;
        logic key_match;
        logic walk_limit;
        logic free_nil;
        logic [1:0] kind;
    } stat_t;
endpackage
`default_nettype wire

// ----- src/chained_hash_key_value_table.sv -----
// Top level of the chained hash key-value table.
// Usage:
// - The input channel (in_valid, in_stall, in_item) carries one operation per
//   item: put, get or remove of a signed 32-bit key, with a value for put.
// - The output channel (out_valid, out_stall, out_item) returns one result
//   item for each operation, in order.
// - After reset a clearing pass empties the bucket heads and links the entry
//   pool into the free list; in_stall is high during it.
// - One item is worked at a time: the bucket head is read, then the chain is
//   walked until the key matches or the chain ends. Each chain entry costs
//   one memory read and one compare.
// - The result sits in an output register; a new item is taken while it waits
//   unless the receiver stalls it, in which case the block holds both sides.
`default_nettype none
module chained_hash_key_value_table #(
    parameter int BUCKETS = 64,
    parameter int ENTRIES = 256,
    parameter int VALUE_BITS = 32
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic in_stall,
    input  wire chkv_pkg::in_item_t in_item,
    output logic out_valid,
    input  wire logic out_stall,
    output chkv_pkg::out_item_t out_item
);
    import chkv_pkg::*;

    cmd_t cmd;
    stat_t stat;

    chkv_ctrl u_ctrl (
        .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
        .out_valid(out_valid), .out_stall(out_stall), .stat(stat), .cmd(cmd)
    );

    chkv_dp #(.BUCKETS(BUCKETS), .ENTRIES(ENTRIES), .VALUE_BITS(VALUE_BITS)) u_dp (
        .clk(clk), .rst_n(rst_n), .in_item(in_item), .cmd(cmd), .stat(stat),
        .out_item(out_item)
    );
endmodule
`default_nettype wire

// ----- src/chkv_ctrl.sv -----
// Controller state machine for the chained hash key-value table.
`default_nettype none
module chkv_ctrl (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic in_valid,
    output logic in_stall,
    output logic out_valid,
    input  wire logic out_stall,
    input  wire chkv_pkg::stat_t stat,
    output chkv_pkg::cmd_t cmd
);
    import chkv_pkg::*;

    state_t state_reg, state_next;
    logic out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign out_valid = out_valid_reg;

    // Next state and command decode.
    always_comb
    begin
        state_next = state_reg;
        cmd = '0;
        out_valid_next = out_valid_reg && out_stall;
        in_stall = 1'b1;
        case (state_reg)
            ST_INIT:
            begin
                cmd.init_step = 1'b1;
                if (stat.init_done)
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                in_stall = out_valid_reg && out_stall;
                if (in_valid && !in_stall)
                begin
                    cmd.load_item = 1'b1;
                    state_next = ST_HEAD;
                end
            end
            ST_HEAD:
            begin
                cmd.read_head = 1'b1;
                state_next = ST_WALK;
            end
            ST_WALK:
            begin
                if (stat.cur_nil || stat.walk_limit)
                begin
                    if (stat.kind == KIND_PUT)
                    begin
                        cmd.read_free = 1'b1;
                        state_next = ST_PUTNEW;
                    end
                    else
                        state_next = ST_DONE;
                end
                else
                begin
                    cmd.read_entry = 1'b1;
                    state_next = ST_CMP;
                end
            end
            ST_CMP:
            begin
                if (stat.key_match)
                begin
                    case (stat.kind)
                        KIND_PUT:
                        begin
                            cmd.do_replace = 1'b1;
                            state_next = ST_DONE;
                        end
                        KIND_GET:
                        begin
                            cmd.do_get = 1'b1;
                            state_next = ST_DONE;
                        end
                        KIND_REMOVE:
                        begin
                            cmd.do_unlink = 1'b1;
                            state_next = ST_REMOVE;
                        end
                        default: state_next = ST_DONE;
                    endcase
                end
                else
                begin
                    cmd.advance = 1'b1;
                    state_next = ST_WALK;
                end
            end
            ST_PUTNEW:
            begin
                if (stat.free_nil)
                begin
                    cmd.do_full = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    cmd.do_insert = 1'b1;
                    state_next = ST_PUTFREE;
                end
            end
            ST_PUTFREE:
            begin
                state_next = ST_DONE;
            end
            ST_REMOVE:
            begin
                cmd.do_remove = 1'b1;
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (!(out_valid_reg && out_stall))
                begin
                    cmd.do_finish = 1'b1;
                    out_valid_next = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end
endmodule
`default_nettype wire

// ----- src/chkv_dp.sv -----
// Datapath of the chained hash key-value table: memories, walk registers, result.
`default_nettype none
module chkv_dp #(
    parameter int BUCKETS = 64,
    parameter int ENTRIES = 256,
    parameter int VALUE_BITS = 32
) (
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire chkv_pkg::in_item_t in_item,
    input  wire chkv_pkg::cmd_t cmd,
    output chkv_pkg::stat_t stat,
    output chkv_pkg::out_item_t out_item
);
    import chkv_pkg::*;

    localparam int IW = $clog2(ENTRIES + 1);
    localparam int BW = (BUCKETS > 1) ? $clog2(BUCKETS) : 1;
    localparam int SW = $clog2(ENTRIES + 1);
    localparam logic [IW-1:0] NIL = IW'(ENTRIES);
    localparam int IDXW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int MAXD = (BUCKETS > ENTRIES) ? BUCKETS : ENTRIES;
    localparam int CW = $clog2(MAXD + 1);

    logic [IW-1:0] head_mem [BUCKETS];
    logic [31:0] key_mem [ENTRIES];
    logic [VALUE_BITS-1:0] val_mem [ENTRIES];
    logic [IW-1:0] link_mem [ENTRIES];

    logic [1:0] kind_reg;
    logic [31:0] key_reg;
    logic [VALUE_BITS-1:0] val_reg;
    logic [BW-1:0] bkt_reg;
    logic [IW-1:0] cur_reg, prev_reg, free_reg;
    logic [CW-1:0] init_reg;
    logic [SW-1:0] steps_reg, count_reg;
    logic [31:0] rd_key_reg;
    logic [VALUE_BITS-1:0] rd_val_reg;
    logic [IW-1:0] rd_link_reg, head_rd_reg, free_link_reg;
    logic found_reg, rvalid_reg, status_reg;
    logic [31:0] vout_reg, rval_reg;
    out_item_t out_reg;

    logic [31:0] masked;
    logic [BW-1:0] bkt_next;

    // Bucket select: masked key modulo the bucket count.
    assign masked = 32'(in_item.key) & HASH_MASK;
    assign bkt_next = BW'(masked % 32'(BUCKETS));

    function automatic logic [IDXW-1:0] ix(input logic [IW-1:0] v);
        return IDXW'(v);
    endfunction

    // Control and index registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_reg <= '0;
            free_reg <= '0;
            count_reg <= '0;
        end
        else
        begin
            if (cmd.init_step)
                init_reg <= init_reg + 1'b1;
            if (cmd.do_insert)
            begin
                free_reg <= free_link_reg;
                count_reg <= count_reg + 1'b1;
            end
            if (cmd.do_remove)
            begin
                free_reg <= cur_reg;
                if (count_reg != '0)
                    count_reg <= count_reg - 1'b1;
            end
        end
    end

    // Memories and walk datapath.
    always_ff @(posedge clk)
    begin
        if (cmd.init_step)
        begin
            if (init_reg < CW'(BUCKETS))
                head_mem[BW'(init_reg)] <= NIL;
            if (init_reg < CW'(ENTRIES))
                link_mem[IDXW'(init_reg)] <= IW'(init_reg + 1'b1);
        end
        if (cmd.load_item)
        begin
            kind_reg <= in_item.kind;
            key_reg <= 32'(in_item.key);
            val_reg <= VALUE_BITS'(in_item.value);
            bkt_reg <= bkt_next;
            found_reg <= 1'b0;
            rvalid_reg <= 1'b0;
            status_reg <= 1'b0;
            vout_reg <= '0;
            rval_reg <= '0;
        end
        if (cmd.read_head)
        begin
            cur_reg <= head_mem[bkt_reg];
            head_rd_reg <= head_mem[bkt_reg];
            prev_reg <= NIL;
            steps_reg <= '0;
        end
        if (cmd.read_entry)
        begin
            rd_key_reg <= key_mem[ix(cur_reg)];
            rd_val_reg <= val_mem[ix(cur_reg)];
            rd_link_reg <= link_mem[ix(cur_reg)];
        end
        if (cmd.read_free)
            free_link_reg <= link_mem[ix(free_reg)];
        if (cmd.advance)
        begin
            prev_reg <= cur_reg;
            cur_reg <= rd_link_reg;
            steps_reg <= steps_reg + 1'b1;
        end
        if (cmd.do_replace)
        begin
            found_reg <= 1'b1;
            rvalid_reg <= 1'b1;
            rval_reg <= 32'(rd_val_reg);
            val_mem[ix(cur_reg)] <= val_reg;
        end
        if (cmd.do_get)
        begin
            found_reg <= 1'b1;
            vout_reg <= 32'(rd_val_reg);
        end
        if (cmd.do_full)
            status_reg <= 1'b1;
        if (cmd.do_insert)
        begin
            key_mem[ix(free_reg)] <= key_reg;
            val_mem[ix(free_reg)] <= val_reg;
            link_mem[ix(free_reg)] <= head_rd_reg;
            head_mem[bkt_reg] <= free_reg;
        end
        // Unlink the matching entry from its chain.
        if (cmd.do_unlink)
        begin
            found_reg <= 1'b1;
            rvalid_reg <= 1'b1;
            rval_reg <= 32'(rd_val_reg);
            if (prev_reg != NIL)
                link_mem[ix(prev_reg)] <= rd_link_reg;
            else
                head_mem[bkt_reg] <= rd_link_reg;
        end
        // Push the unlinked entry onto the free list in the cycle after the unlink.
        if (cmd.do_remove)
            link_mem[ix(cur_reg)] <= free_reg;
        if (cmd.do_finish)
        begin
            out_reg.found <= found_reg;
            out_reg.value_out <= vout_reg;
            out_reg.released_valid <= rvalid_reg;
            out_reg.released_value <= rval_reg;
            out_reg.status <= status_reg;
            out_reg.entry_count <= 9'(count_reg);
        end
    end

    assign stat.init_done = (init_reg >= CW'(MAXD - 1)) && cmd.init_step;
    assign stat.cur_nil = (cur_reg >= NIL) || (kind_reg > KIND_REMOVE);
    assign stat.key_match = (rd_key_reg == key_reg);
    assign stat.walk_limit = (steps_reg >= SW'(ENTRIES));
    assign stat.free_nil = (free_reg >= NIL);
    assign stat.kind = kind_reg;
    assign out_item = out_reg;
endmodule
`default_nettype wire

// ----- src/chkv_checker.sv -----
// Port-level checker for the chained hash key-value table, bound to the top.
`default_nettype none
`include "assert_macros.svh"
module chkv_checker (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic in_valid,
    input wire logic in_stall,
    input wire logic out_valid,
    input wire logic out_stall,
    input wire chkv_pkg::out_item_t out_item
);
    import chkv_pkg::*;

    // A stalled result holds.
    `CHK_NEXT(a_out_hold, clk, rst_n, out_valid && out_stall, out_valid && $stable(out_item))
    // Table full only on a put miss.
    `CHK_IMPL(a_full, clk, rst_n, out_valid && out_item.status, !out_item.found)
    // A released value always belongs to a key that was found.
    `CHK_IMPL(a_rel, clk, rst_n, out_valid && out_item.released_valid, out_item.found)
    // An accepted item is not followed by a result in the next cycle.
    `CHK_NEXT(a_lat, clk, rst_n, in_valid && !in_stall && !(out_valid && out_stall), !out_valid)
endmodule

bind chained_hash_key_value_table chkv_checker u_chk (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item)
);
`default_nettype wire

// ----- verif/tb_chained_hash_key_value_table.sv -----
// Testbench for the chained hash key-value table: directed and random table operations.
`default_nettype none
module tb_chained_hash_key_value_table;
    timeunit 1ns;
    timeprecision 1ps;
    import chkv_pkg::*;

    localparam int BUCKETS = 64;
    localparam int ENTRIES = 256;
    localparam int NIL = ENTRIES;
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam longint CYCLE_LIMIT = 400000;

    logic clk = 1'b0;
    logic rst_n;
    logic in_valid;
    logic in_stall;
    in_item_t in_item;
    logic out_valid;
    logic out_stall;
    out_item_t out_item;

    chained_hash_key_value_table #(
        .BUCKETS(BUCKETS),
        .ENTRIES(ENTRIES),
        .VALUE_BITS(32)
    ) DUT (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_item(in_item),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_item(out_item)
    );

    // Shadow copy of the table.
    int unsigned bucket_first [BUCKETS];
    logic [31:0] slot_key [ENTRIES];
    logic [31:0] slot_value [ENTRIES];
    int unsigned slot_next [ENTRIES];
    int unsigned free_first;
    int unsigned live_count;

    out_item_t expected_results [$];
    int error_count;
    bit idle_enable;
    longint cycle_count;
    logic [31:0] key_pool [16];

    // Clock with a 10 ns period.
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned bucket_index(logic [31:0] key);
        return (key & HASH_MASK) % BUCKETS;
    endfunction

    function automatic void clear_table();
        for (int i = 0; i < BUCKETS; i++)
            bucket_first[i] = NIL;
        for (int i = 0; i < ENTRIES; i++)
        begin
            slot_key[i] = '0;
            slot_value[i] = '0;
            slot_next[i] = i + 1;
        end
        free_first = 0;
        live_count = 0;
    endfunction

    // Apply one operation to the shadow table and return its result.
    function automatic out_item_t apply_operation(in_item_t op);
        out_item_t res;
        int unsigned cur;
        int unsigned prev;
        int unsigned hit;
        int unsigned steps;
        int unsigned slot;
        int unsigned b;
        res = '0;
        if (op.kind != KIND_UNUSED)
        begin
            b = bucket_index(op.key);
            cur = bucket_first[b];
            prev = NIL;
            hit = NIL;
            steps = 0;
            while (cur < NIL && steps < ENTRIES)
            begin
                if (slot_key[cur] == op.key)
                begin
                    hit = cur;
                    break;
                end
                prev = cur;
                cur = slot_next[cur];
                steps++;
            end
            res.found = (hit < NIL);
            if (op.kind == KIND_PUT)
            begin
                if (hit < NIL)
                begin
                    res.released_valid = 1'b1;
                    res.released_value = slot_value[hit];
                    slot_value[hit] = op.value;
                end
                else if (free_first < NIL)
                begin
                    slot = free_first;
                    free_first = slot_next[slot];
                    slot_key[slot] = op.key;
                    slot_value[slot] = op.value;
                    slot_next[slot] = bucket_first[b];
                    bucket_first[b] = slot;
                    live_count++;
                end
                else
                    res.status = 1'b1;
            end
            else if (op.kind == KIND_GET)
            begin
                if (hit < NIL)
                    res.value_out = slot_value[hit];
            end
            else if (hit < NIL)
            begin
                if (prev < NIL)
                    slot_next[prev] = slot_next[hit];
                else
                    bucket_first[b] = slot_next[hit];
                res.released_valid = 1'b1;
                res.released_value = slot_value[hit];
                slot_next[hit] = free_first;
                free_first = hit;
                if (live_count > 0)
                    live_count--;
            end
        end
        res.entry_count = live_count[8:0];
        return res;
    endfunction

    // Send one item, with an optional random gap before it. Valid stays high
    // after an accept so that a following item goes out back to back.
    task automatic send_item(logic [1:0] kind, logic [31:0] key, logic [31:0] value);
        in_item_t op;
        int gap;
        if (idle_enable && $urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 16);
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        op.kind = kind;
        op.key = key;
        op.value = value;
        in_valid <= 1'b1;
        in_item <= op;
        do
            @(posedge clk);
        while (in_stall);
        expected_results.push_back(apply_operation(op));
    endtask

    // Compare each accepted result with the oldest expectation.
    always @(posedge clk)
    begin
        out_item_t exp_res;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $error("unexpected result item");
                error_count++;
            end
            else
            begin
                exp_res = expected_results.pop_front();
                if (out_item.found !== exp_res.found)
                begin
                    $error("found: expected %0h actual %0h", exp_res.found, out_item.found);
                    error_count++;
                end
                if (out_item.value_out !== exp_res.value_out)
                begin
                    $error("value_out: expected %0h actual %0h",
                           exp_res.value_out, out_item.value_out);
                    error_count++;
                end
                if (out_item.released_valid !== exp_res.released_valid)
                begin
                    $error("released_valid: expected %0h actual %0h",
                           exp_res.released_valid, out_item.released_valid);
                    error_count++;
                end
                if (out_item.released_value !== exp_res.released_value)
                begin
                    $error("released_value: expected %0h actual %0h",
                           exp_res.released_value, out_item.released_value);
                    error_count++;
                end
                if (out_item.status !== exp_res.status)
                begin
                    $error("status: expected %0h actual %0h", exp_res.status, out_item.status);
                    error_count++;
                end
                if (out_item.entry_count !== exp_res.entry_count)
                begin
                    $error("entry_count: expected %0d actual %0d",
                           exp_res.entry_count, out_item.entry_count);
                    error_count++;
                end
            end
        end
    end

    // Receiver stalls in random bursts.
    initial
    begin
        int burst;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (idle_enable && $urandom_range(0, 5) == 0)
            begin
                burst = $urandom_range(1, 16);
                out_stall <= 1'b1;
                repeat (burst) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Watchdog on the whole run.
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    function automatic logic [31:0] random_key();
        return key_pool[$urandom_range(0, 15)];
    endfunction

    // Extremes of key and value, every operation and misses on an empty table.
    task automatic test_directed();
        send_item(KIND_GET, 32'h0000_0000, 32'h0);
        send_item(KIND_REMOVE, 32'h8000_0000, 32'h0);
        send_item(KIND_PUT, 32'h8000_0000, 32'hffff_ffff);
        send_item(KIND_PUT, 32'h0000_0000, 32'h0000_0000);
        send_item(KIND_PUT, 32'h7fff_ffff, 32'h1234_5678);
        send_item(KIND_PUT, 32'hffff_ffff, 32'h8765_4321);
        send_item(KIND_GET, 32'h8000_0000, 32'h5555_5555);
        send_item(KIND_GET, 32'hffff_ffff, 32'h0);
        send_item(KIND_PUT, 32'h8000_0000, 32'haaaa_aaaa);
        send_item(KIND_UNUSED, 32'h7fff_ffff, 32'hffff_ffff);
        send_item(KIND_REMOVE, 32'h0000_0000, 32'h0);
        send_item(KIND_REMOVE, 32'h0000_0000, 32'h0);
        send_item(KIND_GET, 32'h0000_0000, 32'h0);
        // Keys that share one bucket build a chain; remove from its middle.
        send_item(KIND_PUT, 32'h0000_0040, 32'h1);
        send_item(KIND_PUT, 32'h8000_0040, 32'h2);
        send_item(KIND_PUT, 32'h0000_0080, 32'h3);
        send_item(KIND_REMOVE, 32'h8000_0040, 32'h0);
        send_item(KIND_GET, 32'h0000_0040, 32'h0);
        send_item(KIND_GET, 32'h0000_0080, 32'h0);
        send_item(KIND_REMOVE, 32'h0000_0080, 32'h0);
    endtask

    // Put more keys than the pool holds so that puts report a full table, then drain part of it.
    task automatic test_pool_full();
        for (int i = 0; i < ENTRIES + 3; i++)
            send_item(KIND_PUT, {$urandom_range(0, 1) ? 1'b1 : 1'b0, 23'h0, i[7:0]} ^
                      (i >= ENTRIES ? 32'h0100_0000 : 32'h0), $urandom());
        for (int i = 0; i < 120; i++)
            send_item(KIND_REMOVE, random_key() & 32'h8000_00ff, 32'h0);
    endtask

    // Random operations on a small key set so that hits and chains are common.
    task automatic test_random(int count);
        logic [1:0] kind;
        logic [31:0] key;
        for (int i = 0; i < count; i++)
        begin
            case ($urandom_range(0, 19))
                0: kind = KIND_UNUSED;
                1, 2, 3, 4, 5, 6, 7: kind = KIND_PUT;
                8, 9, 10, 11, 12, 13: kind = KIND_GET;
                default: kind = KIND_REMOVE;
            endcase
            key = ($urandom_range(0, 9) == 0) ? $urandom() : random_key();
            send_item(kind, key, $urandom());
        end
    endtask

    initial
    begin
        int drain;
        rst_n = 1'b0;
        in_valid = 1'b0;
        in_item = '0;
        error_count = 0;
        cycle_count = 0;
        idle_enable = 1'b1;
        clear_table();
        for (int i = 0; i < 16; i++)
            key_pool[i] = {$urandom_range(0, 1) ? 1'b1 : 1'b0, 25'h0, 6'(i % 4)} +
                          (i * BUCKETS);
        key_pool[15] = $urandom();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        test_directed();
        test_pool_full();
        test_random(600);
        idle_enable = 1'b0;
        test_random(150);
        in_valid <= 1'b0;

        drain = 0;
        while (expected_results.size() != 0 && drain < 100000)
        begin
            @(posedge clk);
            drain++;
        end
        repeat (20) @(posedge clk);
        if (error_count == 0 && expected_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
`default_nettype wire

// ----- chained_hash_key_value_table.f -----
+incdir+src
src/chkv_pkg.sv
src/chkv_ctrl.sv
src/chkv_dp.sv
src/chained_hash_key_value_table.sv
src/chkv_checker.sv
verif/tb_chained_hash_key_value_table.sv
